// ----- sv/tdfg_pkg.sv -----
// shared types, character codes and constant tables for the text display frame generator
// no dependencies; used by the unit, the sequencer, the datapath and the bench
package tdfg_pkg;

  localparam int DEF_LINE_WIDTH = 24;
  localparam int NUM_LINES      = 3;
  localparam int HEAD_LEN       = 7;
  localparam int SUM_LEN        = 3;
  localparam int COMMIT_LEN     = 9;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;

  // source of one stream byte
  typedef enum logic [2:0] {
    K_HEAD_A,
    K_HEAD_B,
    K_MEM,
    K_PAD,
    K_SUM,
    K_COMMIT
  } kind_t;

  // command from the sequencer to the datapath
  typedef struct packed {
    logic       take;
    logic       issue;
    kind_t      kind;
    logic [1:0] line;
    logic       last;
  } cmd_t;

  function automatic logic [7:0] head_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = CH_CR;
      3'd1:    c = CH_A;
      3'd2:    c = 8'h4F;
      3'd6:    c = 8'h31;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] commit_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = CH_CR;
      4'd1:    c = 8'h5A;
      4'd2:    c = 8'h44;
      4'd3:    c = 8'h30;
      4'd4:    c = 8'h30;
      4'd5:    c = 8'h31;
      4'd6:    c = 8'h33;
      4'd7:    c = 8'h43;
      default: c = CH_LF;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'd0, n};
    end else begin
      c = 8'h37 + {4'd0, n};
    end
    return c;
  endfunction

endpackage

// ----- sv/tdfg_rx_if.sv -----
// request channel carrying received text bytes
// no dependencies
interface tdfg_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- sv/tdfg_tx_if.sv -----
// result channel carrying byte pairs for the display link
// no dependencies
interface tdfg_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_first;
  logic [7:0] byte_second;
  logic [1:0] pair_count;
  logic       last_of_run;

  modport source (output valid, output byte_first, output byte_second, output pair_count,
                  output last_of_run, input ready);
  modport sink (input valid, input byte_first, input byte_second, input pair_count,
                input last_of_run, output ready);
endinterface

// ----- sv/text_display_frame_generator_unit.sv -----
// a run emits 29 + LINE_WIDTH + len1 + len2 bytes, one byte per cycle through the single
// line store read port while the result side does not stall; the next request is not
// taken until the sequencer has issued the whole run and is idle again
// reset (synchronous): cursor, write positions and fill counts clear; the line store is
// not swept, bytes beyond a line's fill count are never emitted
module text_display_frame_generator_unit #(
  parameter int LINE_WIDTH = tdfg_pkg::DEF_LINE_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  tdfg_rx_if.sink   rx,
  tdfg_tx_if.source tx
);

  localparam int LENW = $clog2(LINE_WIDTH + 1);

  tdfg_pkg::cmd_t        cmd;
  logic [LENW-1:0]       idx;
  logic                  adv;
  logic [2:0][LENW-1:0]  len;

  tdfg_ctrl #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .adv      (adv),
    .len      (len),
    .cmd      (cmd),
    .idx      (idx)
  );

  tdfg_datapath #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .idx     (idx),
    .rx_byte (rx.rx_byte),
    .adv     (adv),
    .len     (len),
    .tx      (tx)
  );

endmodule

// ----- sv/tdfg_ctrl.sv -----
// sequencer: walks the frame segments and issues one byte command per cycle while the byte stage is not held
// depends on tdfg_pkg
module tdfg_ctrl #(
  parameter int LINE_WIDTH = tdfg_pkg::DEF_LINE_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  rx_valid,
  output logic                                  rx_ready,
  input  logic                                  adv,
  input  logic [2:0][$clog2(LINE_WIDTH+1)-1:0]  len,
  output tdfg_pkg::cmd_t                        cmd,
  output logic [$clog2(LINE_WIDTH+1)-1:0]       idx
);

  localparam int LENW = $clog2(LINE_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_LINE0,
    S_PAD,
    S_LINE1,
    S_LINE2,
    S_SUM,
    S_COMMIT
  } state_t;

  state_t          state, state_next, after;
  logic            frame_b, frame_b_next;
  logic [LENW-1:0] idx_next;
  logic [LENW-1:0] limit;
  logic [LENW:0]   idx_inc;
  logic            done;

  always_comb begin
    limit     = '0;
    after     = S_IDLE;
    cmd.kind  = tdfg_pkg::K_HEAD_A;
    cmd.line  = 2'd0;
    case (state)
      S_HEAD: begin
        limit    = LENW'(tdfg_pkg::HEAD_LEN);
        cmd.kind = frame_b ? tdfg_pkg::K_HEAD_B : tdfg_pkg::K_HEAD_A;
        after    = frame_b ? S_LINE2 : S_LINE0;
      end
      S_LINE0: begin
        limit    = len[0];
        cmd.kind = tdfg_pkg::K_MEM;
        cmd.line = 2'd0;
        after    = S_PAD;
      end
      S_PAD: begin
        limit    = LENW'(LINE_WIDTH) - len[0];
        cmd.kind = tdfg_pkg::K_PAD;
        after    = S_LINE1;
      end
      S_LINE1: begin
        limit    = len[1];
        cmd.kind = tdfg_pkg::K_MEM;
        cmd.line = 2'd1;
        after    = S_SUM;
      end
      S_LINE2: begin
        limit    = len[2];
        cmd.kind = tdfg_pkg::K_MEM;
        cmd.line = 2'd2;
        after    = S_SUM;
      end
      S_SUM: begin
        limit    = LENW'(tdfg_pkg::SUM_LEN);
        cmd.kind = tdfg_pkg::K_SUM;
        after    = frame_b ? S_COMMIT : S_HEAD;
      end
      S_COMMIT: begin
        limit    = LENW'(tdfg_pkg::COMMIT_LEN);
        cmd.kind = tdfg_pkg::K_COMMIT;
        after    = S_IDLE;
      end
      default: begin
        limit = '0;
      end
    endcase

    // an empty segment issues nothing but is still passed through as a state
    idx_inc   = {1'b0, idx} + 1'b1;
    done      = (idx_inc >= {1'b0, limit});
    cmd.issue = (state != S_IDLE) && (idx < limit);
    cmd.last  = (state == S_COMMIT) && done;
    cmd.take  = (state == S_IDLE) && rx_valid;
    rx_ready  = (state == S_IDLE);

    state_next   = state;
    frame_b_next = frame_b;
    idx_next     = idx;
    if (state == S_IDLE) begin
      if (rx_valid) begin
        state_next   = S_HEAD;
        frame_b_next = 1'b0;
        idx_next     = '0;
      end
    end else if (adv) begin
      if (done) begin
        state_next = after;
        idx_next   = '0;
        if (state == S_SUM) begin
          frame_b_next = 1'b1;
        end
      end else begin
        idx_next = idx_inc[LENW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      frame_b <= 1'b0;
      idx     <= '0;
    end else begin
      state   <= state_next;
      frame_b <= frame_b_next;
      idx     <= idx_next;
    end
  end

endmodule

// ----- sv/tdfg_datapath.sv -----
// datapath: line store, cursor and fill state, byte selection, frame checksum and pair packer
// depends on tdfg_pkg and tdfg_tx_if
module tdfg_datapath #(
  parameter int LINE_WIDTH = tdfg_pkg::DEF_LINE_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tdfg_pkg::cmd_t                        cmd,
  input  logic [$clog2(LINE_WIDTH+1)-1:0]       idx,
  input  logic [7:0]                            rx_byte,
  output logic                                  adv,
  output logic [2:0][$clog2(LINE_WIDTH+1)-1:0]  len,
  tdfg_tx_if.source                             tx
);

  localparam int LENW  = $clog2(LINE_WIDTH + 1);
  localparam int POSW  = $clog2(LINE_WIDTH);
  localparam int DEPTH = tdfg_pkg::NUM_LINES * LINE_WIDTH;
  localparam int ADDRW = $clog2(DEPTH);
  localparam logic [ADDRW-1:0] BASE1 = ADDRW'(LINE_WIDTH);
  localparam logic [ADDRW-1:0] BASE2 = ADDRW'(2 * LINE_WIDTH);

  logic [7:0]            mem [DEPTH];
  logic [2:0][POSW-1:0]  pos;
  logic [1:0]            cur, cur_next;
  logic                  is_plus, is_sel, is_store;
  logic [POSW-1:0]       wpos, wpos_inc;
  logic [ADDRW-1:0]      waddr, raddr;
  logic [7:0]            rdata;

  logic                  s1_valid;
  tdfg_pkg::kind_t       s1_kind;
  logic [LENW-1:0]       s1_idx;
  logic                  s1_last;
  logic [7:0]            sel_byte;
  logic                  consume;
  logic [7:0]            sum;
  logic                  have_first;
  logic [7:0]            first_byte;
  logic                  out_valid;
  logic [7:0]            out_first, out_second;
  logic [1:0]            out_count;
  logic                  out_last;

  function automatic logic [ADDRW-1:0] base_of(input logic [1:0] ln);
    logic [ADDRW-1:0] b;
    case (ln)
      2'd1:    b = BASE1;
      2'd2:    b = BASE2;
      default: b = '0;
    endcase
    return b;
  endfunction

  // request decode and store update
  always_comb begin
    is_plus  = (rx_byte == tdfg_pkg::CH_PLUS);
    is_sel   = rx_byte inside {[tdfg_pkg::CH_ONE:tdfg_pkg::CH_THREE]};
    is_store = !is_plus && !is_sel && (rx_byte != tdfg_pkg::CH_NUL);
    cur_next = cur;
    if (is_plus) begin
      cur_next = (cur == 2'd2) ? 2'd0 : cur + 2'd1;
    end else if (is_sel) begin
      cur_next = 2'(rx_byte - tdfg_pkg::CH_ONE);
    end
    wpos     = pos[cur];
    wpos_inc = (wpos == POSW'(LINE_WIDTH - 1)) ? '0 : wpos + 1'b1;
    waddr    = base_of(cur) + ADDRW'(wpos);
    raddr    = base_of(cmd.line) + ADDRW'(idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= 2'd0;
      pos <= '0;
      len <= '0;
    end else if (cmd.take) begin
      cur <= cur_next;
      if (is_store) begin
        pos[cur] <= wpos_inc;
        if (len[cur] != LENW'(LINE_WIDTH)) begin
          len[cur] <= len[cur] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && is_store) begin
      mem[waddr] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata <= mem[raddr];
    end
  end

  // byte stage, held while the output register is full and not taken
  assign adv     = !out_valid || tx.ready;
  assign consume = s1_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= cmd.issue;
    end
    if (adv) begin
      s1_kind <= cmd.kind;
      s1_idx  <= idx;
      s1_last <= cmd.last;
    end
  end

  always_comb begin
    case (s1_kind)
      tdfg_pkg::K_HEAD_A, tdfg_pkg::K_HEAD_B: begin
        if (s1_idx == LENW'(1)) begin
          sel_byte = (s1_kind == tdfg_pkg::K_HEAD_B) ? tdfg_pkg::CH_B : tdfg_pkg::CH_A;
        end else begin
          sel_byte = tdfg_pkg::head_char(s1_idx[2:0]);
        end
      end
      tdfg_pkg::K_MEM: sel_byte = rdata;
      tdfg_pkg::K_PAD: sel_byte = tdfg_pkg::CH_SPACE;
      tdfg_pkg::K_SUM: begin
        if (s1_idx == '0) begin
          sel_byte = tdfg_pkg::hex_char(sum[7:4]);
        end else if (s1_idx == LENW'(1)) begin
          sel_byte = tdfg_pkg::hex_char(sum[3:0]);
        end else begin
          sel_byte = tdfg_pkg::CH_LF;
        end
      end
      tdfg_pkg::K_COMMIT: sel_byte = tdfg_pkg::commit_char(s1_idx[3:0]);
      default: sel_byte = tdfg_pkg::CH_NUL;
    endcase
  end

  // checksum restarts on the first header byte; the checksum digits, their line feed and commit bytes are not summed
  always_ff @(posedge clk) begin
    if (consume) begin
      if (s1_kind inside {tdfg_pkg::K_HEAD_A, tdfg_pkg::K_HEAD_B}) begin
        sum <= (s1_idx == '0) ? sel_byte : sum + sel_byte;
      end else if (s1_kind inside {tdfg_pkg::K_MEM, tdfg_pkg::K_PAD}) begin
        sum <= sum + sel_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_first <= 1'b0;
      out_valid  <= 1'b0;
    end else if (consume) begin
      if (have_first) begin
        out_first  <= first_byte;
        out_second <= sel_byte;
        out_count  <= 2'd2;
        out_last   <= s1_last;
        out_valid  <= 1'b1;
        have_first <= 1'b0;
      end else if (s1_last) begin
        out_first  <= sel_byte;
        out_second <= tdfg_pkg::CH_NUL;
        out_count  <= 2'd1;
        out_last   <= 1'b1;
        out_valid  <= 1'b1;
      end else begin
        first_byte <= sel_byte;
        have_first <= 1'b1;
        out_valid  <= 1'b0;
      end
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign tx.valid       = out_valid;
  assign tx.byte_first  = out_first;
  assign tx.byte_second = out_second;
  assign tx.pair_count  = out_count;
  assign tx.last_of_run = out_last;

`ifndef SYNTHESIS
  a_cur_range: assert property (@(posedge clk) disable iff (rst) cur != 2'd3)
    else $error("current line out of range");
  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_count == 2'd1) |-> out_last)
    else $error("single byte result not at end of run");
  a_last_flushes: assert property (@(posedge clk) disable iff (rst)
    consume && s1_last |=> !have_first && out_valid)
    else $error("packer not flushed at end of run");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (len[0] <= LENW'(LINE_WIDTH)) && (len[1] <= LENW'(LINE_WIDTH))
    && (len[2] <= LENW'(LINE_WIDTH)))
    else $error("line fill count beyond line width");
`endif

endmodule

// ----- tb/tb_text_display_frame_generator_unit.sv -----
// self-checking bench for the text display frame generator: directed and random text requests in,
// every byte pair of both display frames and the commit string checked in order
// depends on tdfg_pkg, tdfg_rx_if, tdfg_tx_if and text_display_frame_generator_unit
module tb_text_display_frame_generator_unit;

  localparam int LINE_WIDTH   = tdfg_pkg::DEF_LINE_WIDTH;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 77;
  localparam logic [39:0] HEAD_TAIL   = "O0001";
  localparam logic [55:0] COMMIT_BODY = "ZD0013C";

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [1:0] count;
    logic       last;
  } byte_pair_t;

  logic clk;
  logic rst;

  tdfg_rx_if rx ();
  tdfg_tx_if tx ();

  text_display_frame_generator_unit #(
    .LINE_WIDTH(LINE_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .rx (rx),
    .tx (tx)
  );

  // shadow copy of the text lines and cursor
  logic [7:0] line_text [tdfg_pkg::NUM_LINES][LINE_WIDTH];
  int         wr_pos    [tdfg_pkg::NUM_LINES];
  int         fill_len  [tdfg_pkg::NUM_LINES];
  int         cur_line;

  logic [7:0] rx_bytes_pending [$];
  byte_pair_t frame_pairs_due  [$];

  int err_count      = 0;
  int pairs_checked  = 0;
  int requests_taken = 0;
  int wraps_seen     = 0;
  int cycle_count    = 0;
  int rx_gap         = 0;
  int tx_stall       = 0;
  int rx_quiet       = 0;
  int tx_quiet       = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, a few long ones, now and then a stretch with none at all
  function automatic int draw_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 60);
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + {4'd0, n} : 8'h41 + {4'd0, n} - 8'd10;
  endfunction

  // apply one received byte, then queue the byte pairs of both frames and the commit
  function automatic void build_frames(input logic [7:0] c);
    logic [7:0] stream [$];
    logic [7:0] sum;
    byte_pair_t p;
    int         ln;
    int         pos;
    int         start;
    int         i;
    ln = cur_line;
    if (c == tdfg_pkg::CH_PLUS) begin
      cur_line = (ln + 1) % tdfg_pkg::NUM_LINES;
    end else if (c >= tdfg_pkg::CH_ONE && c <= tdfg_pkg::CH_THREE) begin
      cur_line = c - tdfg_pkg::CH_ONE;
    end else if (c != tdfg_pkg::CH_NUL) begin
      pos = wr_pos[ln];
      line_text[ln][pos] = c;
      pos++;
      if (pos == LINE_WIDTH) begin
        pos = 0;
        wraps_seen++;
      end
      wr_pos[ln] = pos;
      if (fill_len[ln] < LINE_WIDTH) fill_len[ln]++;
    end

    for (int f = 0; f < 2; f++) begin
      start = stream.size();
      stream.push_back(tdfg_pkg::CH_CR);
      stream.push_back((f == 0) ? tdfg_pkg::CH_A : tdfg_pkg::CH_B);
      for (i = 0; i < 5; i++) stream.push_back(HEAD_TAIL[8*(4-i) +: 8]);
      if (f == 0) begin
        for (i = 0; i < LINE_WIDTH; i++)
          stream.push_back((i < fill_len[0]) ? line_text[0][i] : tdfg_pkg::CH_SPACE);
        for (i = 0; i < fill_len[1]; i++) stream.push_back(line_text[1][i]);
      end else begin
        for (i = 0; i < fill_len[2]; i++) stream.push_back(line_text[2][i]);
      end
      sum = 8'd0;
      for (i = start; i < stream.size(); i++) sum = sum + stream[i];
      stream.push_back(hex_digit(sum[7:4]));
      stream.push_back(hex_digit(sum[3:0]));
      stream.push_back(tdfg_pkg::CH_LF);
    end
    stream.push_back(tdfg_pkg::CH_CR);
    for (i = 0; i < 7; i++) stream.push_back(COMMIT_BODY[8*(6-i) +: 8]);
    stream.push_back(tdfg_pkg::CH_LF);

    for (i = 0; i < stream.size(); i += 2) begin
      p.first = stream[i];
      if (i + 1 < stream.size()) begin
        p.second = stream[i+1];
        p.count  = 2'd2;
      end else begin
        p.second = 8'd0;
        p.count  = 2'd1;
      end
      p.last = (i + 2 >= stream.size());
      frame_pairs_due.push_back(p);
    end
  endfunction

  function automatic void check_field(input string label, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      rx.valid   <= 1'b0;
      rx.rx_byte <= 8'd0;
      rx_gap     <= 0;
    end else begin
      if (rx.valid && rx.ready) begin
        build_frames(rx.rx_byte);
        requests_taken++;
      end
      if (!rx.valid || rx.ready) begin
        if (rx_gap > 0) begin
          rx.valid <= 1'b0;
          rx_gap   <= rx_gap - 1;
        end else if (rx_bytes_pending.size() > 0) begin
          rx.valid   <= 1'b1;
          rx.rx_byte <= rx_bytes_pending.pop_front();
          rx_gap     <= draw_gap(rx_quiet);
        end else begin
          rx.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    byte_pair_t want;
    if (rst) begin
      tx.ready <= 1'b0;
      tx_stall <= 0;
    end else begin
      if (tx.valid && tx.ready) begin
        if (frame_pairs_due.size() == 0) begin
          err_count++;
          $display("%0t: unexpected pair, expected none, actual %h %h %0d %b", $time,
                    tx.byte_first, tx.byte_second, tx.pair_count, tx.last_of_run);
        end else begin
          want = frame_pairs_due.pop_front();
          check_field("byte_first", want.first, tx.byte_first);
          check_field("byte_second", want.second, tx.byte_second);
          check_field("pair_count", {6'd0, want.count}, {6'd0, tx.pair_count});
          check_field("last_of_run", {7'd0, want.last}, {7'd0, tx.last_of_run});
          pairs_checked++;
        end
      end
      if (tx_stall > 0) begin
        tx.ready <= 1'b0;
        tx_stall <= tx_stall - 1;
      end else begin
        tx.ready <= 1'b1;
        tx_stall <= draw_gap(tx_quiet);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int         sent;
    int         run_len;
    int         r;
    logic [7:0] sel;
    rst        = 1'b1;
    cur_line   = 0;
    for (int l = 0; l < tdfg_pkg::NUM_LINES; l++) begin
      wr_pos[l]   = 0;
      fill_len[l] = 0;
      for (int i = 0; i < LINE_WIDTH; i++) line_text[l][i] = 8'd0;
    end

    // directed: nul on empty lines, byte extremes, every line select and the advance
    rx_bytes_pending = '{tdfg_pkg::CH_NUL, 8'hFF, 8'h01, 8'h80, tdfg_pkg::CH_PLUS, 8'h7F,
                         tdfg_pkg::CH_PLUS, 8'h55, 8'hAA, tdfg_pkg::CH_PLUS,
                         tdfg_pkg::CH_THREE, 8'h20, tdfg_pkg::CH_NUL,
                         tdfg_pkg::CH_ONE + 8'd1, 8'h2C, 8'h30, 8'h34, tdfg_pkg::CH_ONE,
                         8'h2A, tdfg_pkg::CH_NUL, tdfg_pkg::CH_PLUS, tdfg_pkg::CH_PLUS,
                         8'h7E};

    // random: pick or advance a line, then write a run of text into it, at times long enough to wrap
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 3);
      sel = (r == 3) ? tdfg_pkg::CH_PLUS : tdfg_pkg::CH_ONE + r[7:0];
      rx_bytes_pending.push_back(sel);
      sent++;
      run_len = $urandom_range(4, 30);
      for (int i = 0; i < run_len && sent < RANDOM_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 5)
          rx_bytes_pending.push_back(tdfg_pkg::CH_NUL);
        else if (r < 12)
          rx_bytes_pending.push_back(8'($urandom_range(0, 255)));
        else
          rx_bytes_pending.push_back(8'($urandom_range(8'h20, 8'h7E)));
        sent++;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (rx_bytes_pending.size() > 0 || rx.valid || frame_pairs_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d text requests taken, %0d byte pairs checked, %0d line wraps",
             requests_taken, pairs_checked, wraps_seen);
    if (err_count == 0 && frame_pairs_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
